>>> rtl/tty_line_discipline_queue_unit_defines.svh
// assertion macros shared by the line discipline queue checker
// no dependencies; expects clk and arst_n in the scope of each use
`ifndef TTY_LINE_DISCIPLINE_QUEUE_UNIT_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TLDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TLDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tldq_pkg.sv
// shared types, codes and constants for the line discipline queue
// no dependencies
package tldq_pkg;

	localparam int TLDQ_DEPTH_DEFAULT = 256;
	localparam int CFG_IDX_W = 3;

	// item functions
	localparam logic [1:0] FUNC_RECV  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_DRIVER = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_CTL       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CR      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CR_TO_NL       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NL_TO_CR       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_POST    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CR_TO_NL   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_NL_TO_CRNL = 3'd7;

	// characters
	localparam logic [7:0] CH_BELL  = 8'h07;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CTL_FLIP = 8'h40;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       last_in_call;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [8:0] room;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic load;        // latch the accepted item
		logic eval;        // apply the item to queue state, build results
		logic sel_second;  // present the second result
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] res_cnt;  // results of the item under evaluation
		logic       two_res;  // stored item has two results
	} ctrl_sts_t;

endpackage

>>> rtl/tldq_ctrl.sv
// sequencer for the line discipline queue: accept, evaluate, deliver beats
// depends on tldq_pkg
module tldq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tldq_pkg::ctrl_cmd_t   cmd,
	input  tldq_pkg::ctrl_sts_t   sts
);
	import tldq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_OUT0 = 4'b0100,
		S_OUT1 = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) state_nx = S_EVAL;
			end
			S_EVAL: begin
				state_nx = (sts.res_cnt == 2'd0) ? S_IDLE : S_OUT0;
			end
			S_OUT0: begin
				if (!result_stall) state_nx = sts.two_res ? S_OUT1 : S_IDLE;
			end
			S_OUT1: begin
				if (!result_stall) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign item_stall     = (state_q != S_IDLE);
	assign result_valid   = (state_q == S_OUT0) || (state_q == S_OUT1);
	assign cmd.load       = (state_q == S_IDLE) && item_valid;
	assign cmd.eval       = (state_q == S_EVAL);
	assign cmd.sel_second = (state_q == S_OUT1);

endmodule

>>> rtl/tldq_dpath.sv
// datapath: registers, receive queue memory, echo and cr/nl translation
// depends on tldq_pkg
module tldq_dpath #(
	parameter int QUEUE_DEPTH = tldq_pkg::TLDQ_DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tldq_pkg::in_item_t              item,
	input  logic                            cfg_we,
	input  logic [tldq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic                            cfg_data,
	input  tldq_pkg::ctrl_cmd_t             cmd,
	output tldq_pkg::ctrl_sts_t             sts,
	output tldq_pkg::out_item_t             result
);
	import tldq_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int RM_W  = (CNT_W > 9) ? CNT_W : 9;
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
	localparam logic [RM_W-1:0]  RM_DEPTH  = RM_W'(QUEUE_DEPTH);

	// configuration
	logic echo_en_q, echo_ctl_q, ignore_cr_q, cr_to_nl_q, nl_to_cr_q;
	logic post_q, ocr_to_nl_q, onl_to_crnl_q;

	// queue state
	logic [7:0]       mem [QUEUE_DEPTH];
	logic [7:0]       rd_data_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             drop_q;

	// item and result plan
	in_item_t   item_q;
	logic [1:0] kind0_q;
	logic [7:0] byte0_q;
	logic [7:0] byte1_q;
	logic       two_q;
	logic       use_rd_q;
	logic [8:0] room_q;

	// evaluation
	logic [7:0]       c;
	logic [7:0]       wc;
	logic             is_ctl;
	logic             full;
	logic             empty;
	logic [1:0]       res_cnt;
	logic [1:0]       kind0;
	logic [7:0]       byte0;
	logic [7:0]       byte1;
	logic             use_rd;
	logic             push;
	logic [7:0]       push_byte;
	logic             pop;
	logic             clr;
	logic             drop_nx;
	logic [CNT_W-1:0] fill_nx;
	logic [RM_W-1:0]  room_full;

	assign c      = item_q.data_byte;
	assign is_ctl = (c < CH_SPACE) || (c == CH_DEL);
	assign full   = (fill_q == CNT_FULL);
	assign empty  = (fill_q == '0);
	assign wc     = (post_q && ocr_to_nl_q && (c == CH_CR)) ? CH_NL : c;

	always_comb begin
		res_cnt   = 2'd0;
		kind0     = KIND_DRIVER;
		byte0     = '0;
		byte1     = '0;
		use_rd    = 1'b0;
		push      = 1'b0;
		push_byte = c;
		pop       = 1'b0;
		clr       = 1'b0;
		drop_nx   = drop_q;
		unique case (item_q.func)
			FUNC_RECV: begin
				if (!drop_q) begin
					if (full) begin
						res_cnt = 2'd1;
						byte0   = CH_BELL;
						drop_nx = 1'b1;
					end else begin
						if (echo_en_q) begin
							if (echo_ctl_q && is_ctl) begin
								res_cnt = 2'd2;
								byte0   = CH_CARET;
								byte1   = c ^ CTL_FLIP;
							end else begin
								res_cnt = 2'd1;
								byte0   = c;
							end
						end
						push = !((c == CH_CR) && ignore_cr_q);
						if ((c == CH_CR) && cr_to_nl_q) begin
							push_byte = CH_NL;
						end else if ((c == CH_NL) && nl_to_cr_q) begin
							push_byte = CH_CR;
						end
					end
				end
				if (item_q.last_in_call) drop_nx = 1'b0;
			end
			FUNC_WRITE: begin
				if (post_q && onl_to_crnl_q && (wc == CH_NL)) begin
					res_cnt = 2'd2;
					byte0   = CH_CR;
					byte1   = wc;
				end else begin
					res_cnt = 2'd1;
					byte0   = wc;
				end
			end
			FUNC_READ: begin
				res_cnt = 2'd1;
				if (empty) begin
					kind0 = KIND_EMPTY;
				end else begin
					kind0  = KIND_DATA;
					use_rd = 1'b1;
					pop    = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				clr = 1'b1;
			end
			default: clr = 1'b0;
		endcase
	end

	always_comb begin
		if (clr) begin
			fill_nx = '0;
		end else if (push) begin
			fill_nx = fill_q + 1'b1;
		end else if (pop) begin
			fill_nx = fill_q - 1'b1;
		end else begin
			fill_nx = fill_q;
		end
	end

	// room wraps to 9 bits for deep queues
	assign room_full = RM_DEPTH - RM_W'(fill_nx);

	// control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q     <= 1'b1;
			echo_ctl_q    <= 1'b1;
			ignore_cr_q   <= 1'b0;
			cr_to_nl_q    <= 1'b1;
			nl_to_cr_q    <= 1'b0;
			post_q        <= 1'b1;
			ocr_to_nl_q   <= 1'b0;
			onl_to_crnl_q <= 1'b1;
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			fill_q        <= '0;
			drop_q        <= 1'b0;
			two_q         <= 1'b0;
			use_rd_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ECHO_ENABLE:    echo_en_q     <= cfg_data;
					CFG_ECHO_CTL:       echo_ctl_q    <= cfg_data;
					CFG_IGNORE_CR:      ignore_cr_q   <= cfg_data;
					CFG_CR_TO_NL:       cr_to_nl_q    <= cfg_data;
					CFG_NL_TO_CR:       nl_to_cr_q    <= cfg_data;
					CFG_OUTPUT_POST:    post_q        <= cfg_data;
					CFG_OUT_CR_TO_NL:   ocr_to_nl_q   <= cfg_data;
					CFG_OUT_NL_TO_CRNL: onl_to_crnl_q <= cfg_data;
					default:            post_q        <= post_q;
				endcase
			end
			if (cmd.eval) begin
				fill_q   <= fill_nx;
				drop_q   <= drop_nx;
				two_q    <= (res_cnt == 2'd2);
				use_rd_q <= use_rd;
				if (clr) begin
					rd_ptr_q <= '0;
					wr_ptr_q <= '0;
				end else begin
					if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
					if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.eval) begin
			kind0_q <= kind0;
			byte0_q <= byte0;
			byte1_q <= byte1;
			room_q  <= room_full[8:0];
		end
	end

	// receive queue memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.eval && push) mem[wr_ptr_q] <= push_byte;
		if (cmd.eval && pop)  rd_data_q <= mem[rd_ptr_q];
	end

	assign sts.res_cnt = res_cnt;
	assign sts.two_res = two_q;

	assign result.kind     = cmd.sel_second ? KIND_DRIVER : kind0_q;
	assign result.out_byte = cmd.sel_second ? byte1_q : (use_rd_q ? rd_data_q : byte0_q);
	assign result.room     = room_q;
	assign result.last     = cmd.sel_second || !two_q;

endmodule

>>> rtl/tty_line_discipline_queue_unit.sv
// latency: an accepted item is evaluated in the next cycle; its first result beat, if any,
// shows in the cycle after that. an item has 0, 1 or 2 result beats, and only one item is
// in flight: the sequencer takes no new item until the last beat of the previous one is taken.
// reset: arst_n clears pointers, fill count, drop flag, sequencer and loads the
// register defaults; queue contents are not cleared and need no clearing pass
// top level of the line discipline queue; depends on tldq_pkg, tldq_ctrl, tldq_dpath
module tty_line_discipline_queue_unit #(
	parameter int QUEUE_DEPTH = tldq_pkg::TLDQ_DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  tldq_pkg::in_item_t              item,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output tldq_pkg::out_item_t             result,
	// register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tldq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic                            cfg_data
);
	import tldq_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	logic      cfg_we;

	// register writes are always accepted, never stalled
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer: idle -> evaluate -> first beat (skipped with no results) -> optional second beat
	tldq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	// queue memory, pointers, echo and translation
	tldq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule

>>> rtl/tldq_checker.sv
// port-level checks for the line discipline queue, bound to the top level
// depends on tldq_pkg and tty_line_discipline_queue_unit_defines.svh
`include "tty_line_discipline_queue_unit_defines.svh"

module tldq_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input tldq_pkg::out_item_t   result
);
	import tldq_pkg::*;

	// one item in flight: no new item while a multi-beat result is pending
	`TLDQ_ASSERT_NOW(a_hold_items, result_valid && !result.last, item_stall, "item taken mid-result")

	// an item is only taken while no result beat is offered
	`TLDQ_ASSERT_NOW(a_take_idle, item_valid && !item_stall, !result_valid, "item taken with beat pending")

	// a non-final beat is followed directly by the next beat
	`TLDQ_ASSERT_NEXT(a_second_beat, result_valid && !result_stall && !result.last, result_valid, "missing second beat")

	// an empty read is a single zero beat
	`TLDQ_ASSERT_NOW(a_empty_read, result_valid && (result.kind == KIND_EMPTY), (result.out_byte == 8'h00) && result.last, "bad empty read beat")

	// stalled beat holds
	`TLDQ_ASSERT_NEXT(a_stall_hold, result_valid && result_stall, result_valid && $stable(result), "stalled beat changed")

endmodule

bind tty_line_discipline_queue_unit tldq_checker u_tldq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> bench/tty_line_discipline_queue_unit_test.sv
// self-checking bench for the tty line discipline queue unit: directed table, then
// random receive calls, writes, reads and clears checked beat by beat against a local model
// depends on tldq_pkg and tty_line_discipline_queue_unit
`timescale 1ns / 100ps

module tty_line_discipline_queue_unit_test;
	import tldq_pkg::*;

	localparam int QDEPTH = TLDQ_DEPTH_DEFAULT;

	// register defaults packed by register index, bit 0 is echo_enable
	localparam logic [7:0] RESET_MODES = 8'hAB;

	// one row of the directed table; n_typed < 0 means the model supplies the beats
	typedef struct {
		in_item_t  stim;
		int        n_typed;
		out_item_t beat_a;
		out_item_t beat_b;
	} row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic      cfg_data = 1'b0;

	// line discipline model state
	logic [7:0] mode = RESET_MODES;
	logic [7:0] rx_store [QDEPTH];
	int         rd_ptr = 0;
	int         wr_ptr = 0;
	int         q_fill = 0;
	bit         drop_rest = 1'b0;

	// beats produced by the latest modeled step
	out_item_t  step_beats [2];
	int         step_count;

	// driver and read beats still owed by the block, oldest first
	out_item_t  tty_beats_due [$];
	row_t       directed_rows [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int fail_count = 0;

	tty_line_discipline_queue_unit #(
		.QUEUE_DEPTH(QDEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic out_item_t beat(logic [1:0] k, logic [7:0] b, logic [8:0] r, logic l);
		out_item_t o;
		o.kind = k;
		o.out_byte = b;
		o.room = r;
		o.last = l;
		return o;
	endfunction

	function automatic void add_row(logic [1:0] f, logic [7:0] b, logic l, int n,
			out_item_t a, out_item_t bb);
		row_t r;
		r.stim.func = f;
		r.stim.data_byte = b;
		r.stim.last_in_call = l;
		r.n_typed = n;
		r.beat_a = a;
		r.beat_b = bb;
		directed_rows.push_back(r);
	endfunction

	function automatic void emit(logic [1:0] k, logic [7:0] b);
		step_beats[step_count].kind = k;
		step_beats[step_count].out_byte = b;
		step_count++;
	endfunction

	// applies one item to the model, leaves its beats in step_beats
	function automatic int discipline_step(in_item_t it);
		logic [7:0] c;
		logic [8:0] room_after;
		c = it.data_byte;
		step_count = 0;
		case (it.func)
			FUNC_RECV: begin
				if (!drop_rest) begin
					if (q_fill >= QDEPTH) begin
						// full queue rings the bell and throws away the rest of the call
						emit(KIND_DRIVER, CH_BELL);
						drop_rest = 1'b1;
					end else begin
						if (mode[CFG_ECHO_ENABLE]) begin
							if (mode[CFG_ECHO_CTL] && (c < CH_SPACE || c == CH_DEL)) begin
								emit(KIND_DRIVER, CH_CARET);
								emit(KIND_DRIVER, c ^ CTL_FLIP);
							end else begin
								emit(KIND_DRIVER, c);
							end
						end
						// echoed cr may still be kept out of the queue
						if (!(c == CH_CR && mode[CFG_IGNORE_CR])) begin
							if (c == CH_CR && mode[CFG_CR_TO_NL])
								c = CH_NL;
							else if (c == CH_NL && mode[CFG_NL_TO_CR])
								c = CH_CR;
							rx_store[wr_ptr] = c;
							wr_ptr = (wr_ptr + 1) % QDEPTH;
							q_fill++;
						end
					end
				end
				// end of a call always stops dropping, even the call that overflowed
				if (it.last_in_call)
					drop_rest = 1'b0;
			end
			FUNC_WRITE: begin
				if (mode[CFG_OUTPUT_POST]) begin
					if (c == CH_CR && mode[CFG_OUT_CR_TO_NL])
						c = CH_NL;
					if (c == CH_NL && mode[CFG_OUT_NL_TO_CRNL])
						emit(KIND_DRIVER, CH_CR);
				end
				emit(KIND_DRIVER, c);
			end
			FUNC_READ: begin
				if (q_fill == 0) begin
					emit(KIND_EMPTY, 8'h00);
				end else begin
					emit(KIND_DATA, rx_store[rd_ptr]);
					rd_ptr = (rd_ptr + 1) % QDEPTH;
					q_fill--;
				end
			end
			default: begin
				// clear leaves the drop state alone
				rd_ptr = 0;
				wr_ptr = 0;
				q_fill = 0;
			end
		endcase
		// every beat of a step reports the room left after the whole step
		room_after = 9'(QDEPTH - q_fill);
		for (int k = 0; k < step_count; k++) begin
			step_beats[k].room = room_after;
			step_beats[k].last = (k == step_count - 1);
		end
		return step_count;
	endfunction

	// bias toward the bytes the discipline treats specially
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(3) != 0)
			return 8'($urandom_range(255));
		case ($urandom_range(7))
			0: return CH_CR;
			1: return CH_NL;
			2: return CH_DEL;
			3: return 8'h00;
			4: return 8'h1F;
			5: return CH_SPACE;
			6: return 8'hFF;
			default: return 8'h7E;
		endcase
	endfunction

	// offers one item, waits for it to be taken, records what it owes
	task automatic send_item(in_item_t stim, int n_typed = -1,
			out_item_t a = '0, out_item_t b = '0);
		int n;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= stim;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		n = discipline_step(stim);
		if (n_typed < 0) begin
			for (int k = 0; k < n; k++)
				tty_beats_due.push_back(step_beats[k]);
		end else begin
			if (n_typed > 0)
				tty_beats_due.push_back(a);
			if (n_typed > 1)
				tty_beats_due.push_back(b);
		end
		items_sent++;
	endtask

	// sender holds off until every owed beat is back, then lets a silent item finish
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (tty_beats_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// all eight mode registers in one burst on the write channel
	task automatic write_modes(logic [7:0] m);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= m[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			mode[i] = m[i];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_chunk();
		in_item_t it;
		int pick;
		int len;
		pick = $urandom_range(99);
		len = $urandom_range(6, 1);
		if (pick < 45) begin
			// one receive call; now and then left open so dropping carries over
			for (int k = 0; k < len; k++) begin
				it.func = FUNC_RECV;
				it.data_byte = pick_byte();
				it.last_in_call = (k == len - 1) && ($urandom_range(9) != 0);
				send_item(it);
			end
		end else if (pick < 78) begin
			for (int k = 0; k < len; k++) begin
				it.func = FUNC_READ;
				it.data_byte = 8'($urandom_range(255));
				it.last_in_call = 1'($urandom_range(1));
				send_item(it);
			end
		end else if (pick < 90) begin
			for (int k = 0; k < (len + 1) / 2; k++) begin
				it.func = FUNC_WRITE;
				it.data_byte = pick_byte();
				it.last_in_call = 1'($urandom_range(1));
				send_item(it);
			end
		end else if (pick < 93) begin
			it.func = FUNC_CLEAR;
			it.data_byte = 8'($urandom_range(255));
			it.last_in_call = 1'($urandom_range(1));
			send_item(it);
		end else if (pick < 98) begin
			// noise: any field pattern at all
			it = 11'($urandom);
			send_item(it);
		end else begin
			wait_idle();
		end
	endtask

	// fill the queue to the brim, overflow it in and out of calls, then drain it dry
	task automatic flood_queue();
		in_item_t it;
		int len;
		it.func = FUNC_RECV;
		while (q_fill < QDEPTH) begin
			len = $urandom_range(12, 1);
			for (int k = 0; k < len; k++) begin
				it.data_byte = pick_byte();
				it.last_in_call = (k == len - 1);
				send_item(it);
			end
		end
		// single byte call on a full queue: bell, no dropping afterwards
		it.data_byte = 8'($urandom_range(255));
		it.last_in_call = 1'b1;
		send_item(it);
		// longer call: bell, then the rest of the call is dropped
		for (int k = 0; k < 4; k++) begin
			it.data_byte = pick_byte();
			it.last_in_call = (k == 3);
			send_item(it);
		end
		it.func = FUNC_READ;
		it.last_in_call = 1'b0;
		while (q_fill > 0)
			send_item(it);
		// one more read finds it empty
		send_item(it);
	endtask

	// result side: random stall, each taken beat checked against the oldest owed one
	always @(posedge clk) begin
		out_item_t want;
		result_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && result_valid && !result_stall) begin
			if (tty_beats_due.size() == 0) begin
				$error("unexpected result beat: kind %0d byte %02h room %0d last %0d",
					result.kind, result.out_byte, result.room, result.last);
				fail_count++;
			end else begin
				want = tty_beats_due.pop_front();
				if (result.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, result.kind);
					fail_count++;
				end
				if (result.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte, result.out_byte);
					fail_count++;
				end
				if (result.room !== want.room) begin
					$error("room: expected %0d, got %0d", want.room, result.room);
					fail_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int seg_start;
		logic [7:0] seg_modes;

		// directed table under the reset modes: echo and control echo on,
		// received cr becomes nl, written nl goes out as cr nl
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_EMPTY, 8'h00, 9'd256, 1'b1), '0);
		add_row(FUNC_WRITE, 8'h00, 1'b0, 1, beat(KIND_DRIVER, 8'h00, 9'd256, 1'b1), '0);
		add_row(FUNC_WRITE, 8'hFF, 1'b0, 1, beat(KIND_DRIVER, 8'hFF, 9'd256, 1'b1), '0);
		add_row(FUNC_WRITE, CH_CR, 1'b0, 1, beat(KIND_DRIVER, CH_CR, 9'd256, 1'b1), '0);
		add_row(FUNC_WRITE, CH_NL, 1'b0, 2, beat(KIND_DRIVER, CH_CR, 9'd256, 1'b0),
			beat(KIND_DRIVER, CH_NL, 9'd256, 1'b1));
		add_row(FUNC_RECV, 8'h41, 1'b1, 1, beat(KIND_DRIVER, 8'h41, 9'd255, 1'b1), '0);
		// one call of seven bytes, control bytes echo as caret pairs
		add_row(FUNC_RECV, 8'h00, 1'b0, 2, beat(KIND_DRIVER, CH_CARET, 9'd254, 1'b0),
			beat(KIND_DRIVER, 8'h40, 9'd254, 1'b1));
		add_row(FUNC_RECV, CH_DEL, 1'b0, 2, beat(KIND_DRIVER, CH_CARET, 9'd253, 1'b0),
			beat(KIND_DRIVER, 8'h3F, 9'd253, 1'b1));
		add_row(FUNC_RECV, 8'h1F, 1'b0, 2, beat(KIND_DRIVER, CH_CARET, 9'd252, 1'b0),
			beat(KIND_DRIVER, 8'h5F, 9'd252, 1'b1));
		add_row(FUNC_RECV, CH_SPACE, 1'b0, 1, beat(KIND_DRIVER, CH_SPACE, 9'd251, 1'b1), '0);
		add_row(FUNC_RECV, CH_CR, 1'b0, 2, beat(KIND_DRIVER, CH_CARET, 9'd250, 1'b0),
			beat(KIND_DRIVER, 8'h4D, 9'd250, 1'b1));
		add_row(FUNC_RECV, CH_NL, 1'b0, 2, beat(KIND_DRIVER, CH_CARET, 9'd249, 1'b0),
			beat(KIND_DRIVER, 8'h4A, 9'd249, 1'b1));
		add_row(FUNC_RECV, 8'hFF, 1'b1, 1, beat(KIND_DRIVER, 8'hFF, 9'd248, 1'b1), '0);
		// pop everything back in order, the cr comes back as nl
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_DATA, 8'h41, 9'd249, 1'b1), '0);
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_DATA, 8'h00, 9'd250, 1'b1), '0);
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_DATA, CH_DEL, 9'd251, 1'b1), '0);
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_DATA, 8'h1F, 9'd252, 1'b1), '0);
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_DATA, CH_SPACE, 9'd253, 1'b1), '0);
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_DATA, CH_NL, 9'd254, 1'b1), '0);
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_DATA, CH_NL, 9'd255, 1'b1), '0);
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_DATA, 8'hFF, 9'd256, 1'b1), '0);
		// call marker on a write means nothing
		add_row(FUNC_WRITE, 8'h80, 1'b1, 1, beat(KIND_DRIVER, 8'h80, 9'd256, 1'b1), '0);
		add_row(FUNC_RECV, 8'h78, 1'b1, 1, beat(KIND_DRIVER, 8'h78, 9'd255, 1'b1), '0);
		// clear has no beat, the read after it finds the queue empty
		add_row(FUNC_CLEAR, 8'h5A, 1'b0, -1, '0, '0);
		add_row(FUNC_READ, 8'h00, 1'b0, 1, beat(KIND_EMPTY, 8'h00, 9'd256, 1'b1), '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 32;
		stall_pct = 46;
		foreach (directed_rows[i])
			send_item(directed_rows[i].stim, directed_rows[i].n_typed,
				directed_rows[i].beat_a, directed_rows[i].beat_b);

		// six segments: idle pattern changes every two, modes change every one
		for (int seg = 0; seg < 6; seg++) begin
			wait_idle();
			case (seg)
				0: seg_modes = 8'hFF;
				1: seg_modes = 8'h00;
				4: seg_modes = RESET_MODES;
				default: seg_modes = 8'($urandom_range(255));
			endcase
			write_modes(seg_modes);
			if (seg < 2) begin
				send_idle_pct = 32;
				stall_pct = 46;
			end else if (seg < 4) begin
				send_idle_pct = 46;
				stall_pct = 32;
			end else begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			if (seg == 2)
				flood_queue();
			seg_start = items_sent;
			while (items_sent - seg_start < 100)
				random_chunk();
		end

		// let the last beats drain, then a few quiet cycles for stray ones
		wait_idle();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hang guard
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/tldq_pkg.sv
rtl/tldq_ctrl.sv
rtl/tldq_dpath.sv
rtl/tty_line_discipline_queue_unit.sv
rtl/tldq_checker.sv
bench/tty_line_discipline_queue_unit_test.sv
